/* sv/tbpc_pkg.sv */
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and constants of the two-button press classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int THRESH_BITS = 16;
   localparam int INPUT_TIME_BITS = 32;
   localparam int MAX_EVENTS = 3;
   localparam int COUNT_BITS = 2;
   localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = 16'd2000;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_ANY         = 3'd1,
      EV_LEFT_SHORT  = 3'd2,
      EV_RIGHT_SHORT = 3'd3,
      EV_LEFT_LONG   = 3'd4,
      EV_RIGHT_LONG  = 3'd5,
      EV_BOTH_LONG   = 3'd6
   } event_code_type;

   typedef struct packed {
      event_code_type [MAX_EVENTS-1:0] codes;
      logic [COUNT_BITS-1:0]           count;
      logic                            left_stable;
      logic                            right_stable;
   } poll_result_type;

endpackage

/* sv/tbpc_classifier.sv */
// ----------------------------------------------------------------------------
// tbpc_classifier
// Button state registers and the single-pass next-state and event logic.
// ----------------------------------------------------------------------------
module tbpc_classifier #(
   parameter int TIME_BITS = tbpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic                                     left_down,
   input  logic                                     right_down,
   input  logic [tbpc_pkg::INPUT_TIME_BITS-1:0]     time_ms,
   input  logic [tbpc_pkg::THRESH_BITS-1:0]         long_press_ms,
   output tbpc_pkg::poll_result_type                result
);

   logic [1:0]           prev_ff, prev_in;
   logic [1:0]           stable_ff, stable_in;
   logic [1:0]           sup_ff, sup_in;
   logic [1:0]           long_done_ff, long_done_in;
   logic [TIME_BITS-1:0] start_ff [2];
   logic [TIME_BITS-1:0] start_in [2];
   logic                 combo_ff, combo_in;
   logic [TIME_BITS-1:0] combo_start_ff, combo_start_in;
   logic                 combo_done_ff, combo_done_in;
   logic                 any_ff, any_in;

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] thresh;
   logic [TIME_BITS-1:0] combo_elapsed;
   logic [TIME_BITS-1:0] elapsed [2];
   logic [1:0]           sample;
   logic [tbpc_pkg::COUNT_BITS-1:0] n;

   assign now    = TIME_BITS'(time_ms);
   assign thresh = TIME_BITS'(long_press_ms);
   assign sample = {right_down, left_down};

   always_comb begin
      prev_in        = prev_ff;
      stable_in      = stable_ff;
      sup_in         = sup_ff;
      long_done_in   = long_done_ff;
      start_in       = start_ff;
      combo_in       = combo_ff;
      combo_start_in = combo_start_ff;
      combo_done_in  = combo_done_ff;
      any_in         = any_ff;
      combo_elapsed  = now - combo_start_ff;
      elapsed[0]     = '0;
      elapsed[1]     = '0;
      n              = '0;
      result.codes   = {tbpc_pkg::MAX_EVENTS{tbpc_pkg::EV_NONE}};

      if ((left_down || right_down) && !any_ff) begin
         result.codes[n] = tbpc_pkg::EV_ANY;
         n = n + 2'd1;
         any_in = 1'b1;
      end
      if (!left_down && !right_down) begin
         any_in = 1'b0;
      end

      if (left_down && right_down) begin
         stable_in = 2'b11;
         prev_in   = 2'b11;
         if (!combo_ff) begin
            combo_in       = 1'b1;
            combo_start_in = now;
            combo_done_in  = 1'b0;
            sup_in         = 2'b11;
         end else if (!combo_done_ff && combo_elapsed >= thresh) begin
            combo_done_in   = 1'b1;
            long_done_in    = 2'b11;
            result.codes[n] = tbpc_pkg::EV_BOTH_LONG;
            n = n + 2'd1;
         end
      end else begin
         combo_in      = 1'b0;
         combo_done_in = 1'b0;
         for (int b = 0; b < 2; b++) begin
            if (sample[b] != prev_ff[b]) begin
               prev_in[b] = sample[b];
            end else begin
               if (sample[b] != stable_ff[b]) begin
                  stable_in[b] = sample[b];
                  if (sample[b]) begin
                     start_in[b]     = now;
                     long_done_in[b] = 1'b0;
                     sup_in[b]       = 1'b0;
                  end else if (!long_done_ff[b] && !sup_ff[b]) begin
                     result.codes[n] = (b == 0) ? tbpc_pkg::EV_LEFT_SHORT
                                                : tbpc_pkg::EV_RIGHT_SHORT;
                     n = n + 2'd1;
                  end
               end
               elapsed[b] = now - start_in[b];
               if (sample[b] && !long_done_in[b] && elapsed[b] >= thresh) begin
                  long_done_in[b] = 1'b1;
                  result.codes[n] = (b == 0) ? tbpc_pkg::EV_LEFT_LONG
                                             : tbpc_pkg::EV_RIGHT_LONG;
                  n = n + 2'd1;
               end
            end
         end
      end

      if (n == '0) begin
         n = 2'd1;
      end
      result.count        = n;
      result.left_stable  = stable_in[0];
      result.right_stable = stable_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         stable_ff      <= '0;
         sup_ff         <= '0;
         long_done_ff   <= '0;
         start_ff[0]    <= '0;
         start_ff[1]    <= '0;
         combo_ff       <= 1'b0;
         combo_start_ff <= '0;
         combo_done_ff  <= 1'b0;
         any_ff         <= 1'b0;
      end else if (step) begin
         prev_ff        <= prev_in;
         stable_ff      <= stable_in;
         sup_ff         <= sup_in;
         long_done_ff   <= long_done_in;
         start_ff[0]    <= start_in[0];
         start_ff[1]    <= start_in[1];
         combo_ff       <= combo_in;
         combo_start_ff <= combo_start_in;
         combo_done_ff  <= combo_done_in;
         any_ff         <= any_in;
      end
   end

   // The combo flags only live while both buttons are held.
   assert property (@(posedge clock) disable iff (reset)
      combo_done_ff |-> combo_ff)
      else $error("combo long flag set without an active combo");

   assert property (@(posedge clock) disable iff (reset)
      combo_ff |-> (stable_ff == 2'b11 && prev_ff == 2'b11))
      else $error("active combo without both buttons stable-pressed");

endmodule

/* sv/tbpc_event_queue.sv */
// ----------------------------------------------------------------------------
// tbpc_event_queue
// Result register holding the events of one poll and sending one per transfer.
// ----------------------------------------------------------------------------
module tbpc_event_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  tbpc_pkg::poll_result_type    result,
   output logic                         load_ready,
   output logic                         out_valid,
   input  logic                         out_ready,
   output tbpc_pkg::event_code_type     out_code,
   output logic                         out_left,
   output logic                         out_right,
   output logic                         out_last
);

   tbpc_pkg::poll_result_type       res_ff;
   logic [tbpc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            pop;

   assign out_valid  = (count_ff != '0);
   assign pop        = out_valid && out_ready;
   assign load_ready = (count_ff == '0) || (count_ff == 2'd1 && out_ready);
   assign out_code   = res_ff.codes[0];
   assign out_left   = res_ff.left_stable;
   assign out_right  = res_ff.right_stable;
   assign out_last   = (count_ff == 2'd1);

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = result.count;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end else if (pop) begin
         res_ff.codes[0] <= res_ff.codes[1];
         res_ff.codes[1] <= res_ff.codes[2];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0 || (count_ff == 2'd1 && pop)))
      else $error("poll loaded over undelivered results");

   assert property (@(posedge clock) disable iff (reset)
      load |=> (count_ff != '0))
      else $error("loaded poll produced no result");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !load && count_ff > 2'd1) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("result count did not step down after a transfer");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready && !load) |=> (out_valid && $stable(out_code)))
      else $error("stalled result changed");

endmodule

/* sv/two_button_press_classifier_core.sv */
// ----------------------------------------------------------------------------
// two_button_press_classifier_core
// Debounced two-button classifier with short, long, combo and any-press events.
// ----------------------------------------------------------------------------
// Each input transfer is one poll of both buttons with a millisecond time stamp.
// The poll is classified in the cycle it is accepted and yields one to three
// result transfers, one per cycle while rsp_tready is high, the last one flagged
// by rsp_tlast. A poll holds the result register until its last result has
// left; the next poll is accepted in the same cycle as that last result leaves.
// The long-press threshold is written through the csr channel, which is always ready;
// the user must write it only while no poll is in flight; the block does not enforce this.
module two_button_press_classifier_core #(
   parameter int TIME_BITS = tbpc_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // left_down, right_down, time_ms[31:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // event_code[2:0], left_stable, right_stable, zero fill
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [tbpc_pkg::THRESH_BITS-1:0] long_press_ff;
   logic                             req_fire;
   tbpc_pkg::poll_result_type        result;
   tbpc_pkg::event_code_type         out_code;
   logic                             out_left;
   logic                             out_right;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= tbpc_pkg::LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         long_press_ff <= csr_data;
      end
   end

   tbpc_classifier #(
      .TIME_BITS(TIME_BITS)
   ) u_classifier (
      .clock        (clock),
      .reset        (reset),
      .step         (req_fire),
      .left_down    (req_tdata[0]),
      .right_down   (req_tdata[1]),
      .time_ms      (req_tdata[33:2]),
      .long_press_ms(long_press_ff),
      .result       (result)
   );

   tbpc_event_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .result    (result),
      .load_ready(req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_code  (out_code),
      .out_left  (out_left),
      .out_right (out_right),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_right, out_left, out_code};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-button press classifier core.
// ----------------------------------------------------------------------------
// Polls of both buttons go into the request stream. A behavioral copy of the
// classifier turns each accepted poll into the event transfers it must raise.
// Each response transfer is compared with the oldest of those.
// A short table of hand-written polls runs first. It covers reset state,
// short and long presses, the combo, the stale press start, time wrap and a
// zero threshold. Random phases follow, each under its own long-press
// threshold. Both sides of the stream idle at random, and once the response
// side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int IDLE_LIMIT      = 3000;
   localparam int PHASE_POLLS     = 50;
   localparam int PHASE_COUNT     = 8;

   typedef struct packed {
      tbpc_pkg::event_code_type code;
      logic                     left_stable;
      logic                     right_stable;
      logic                     last;
   } press_event_type;

   typedef enum logic {
      ROW_POLL,
      ROW_THRESHOLD
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     left;
      logic                     right;
      logic [31:0]              stamp;
      logic                     typed;
      tbpc_pkg::event_code_type code;
      logic                     left_stable;
      logic                     right_stable;
      logic [15:0]              value;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // left_down, right_down, time_ms[31:0], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // event_code[2:0], left_stable, right_stable, zero fill
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   logic [15:0] hold_threshold;
   logic        prev_sample [2];
   logic        stable_level [2];
   logic        short_blocked [2];
   logic        long_reported [2];
   logic [31:0] press_start [2];
   logic        combo_on;
   logic [31:0] combo_start;
   logic        combo_long_reported;
   logic        any_reported;

   tbpc_pkg::event_code_type poll_events [$];
   press_event_type          awaited_events [$];
   stim_row_type             directed_rows [$];
   press_event_type          arrived;

   bit steady_run;
   bit pressure_done;
   int polls_sent;
   int results_checked;
   int thresholds_written;
   int mismatch_count;
   int idle_cycles;
   int event_tally [8];

   two_button_press_classifier_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic step_button(input int b, input logic pressed, input logic [31:0] now);
      logic [31:0] elapsed;
      if (pressed != prev_sample[b]) begin
         prev_sample[b] = pressed;
         return;
      end
      if (pressed != stable_level[b]) begin
         stable_level[b] = pressed;
         if (pressed) begin
            press_start[b] = now;
            long_reported[b] = 1'b0;
            short_blocked[b] = 1'b0;
         end else if (!long_reported[b] && !short_blocked[b]) begin
            poll_events.push_back((b == 0) ? tbpc_pkg::EV_LEFT_SHORT
                                           : tbpc_pkg::EV_RIGHT_SHORT);
         end
      end
      elapsed = now - press_start[b];
      if (pressed && !long_reported[b] && elapsed >= {16'd0, hold_threshold}) begin
         long_reported[b] = 1'b1;
         poll_events.push_back((b == 0) ? tbpc_pkg::EV_LEFT_LONG
                                        : tbpc_pkg::EV_RIGHT_LONG);
      end
   endtask

   task automatic classify_poll(input logic l, input logic r, input logic [31:0] now);
      logic [31:0] elapsed;
      poll_events.delete();
      if ((l || r) && !any_reported) begin
         poll_events.push_back(tbpc_pkg::EV_ANY);
         any_reported = 1'b1;
      end
      if (!l && !r)
         any_reported = 1'b0;
      if (l && r) begin
         for (int k = 0; k < 2; k++) begin
            stable_level[k] = 1'b1;
            prev_sample[k] = 1'b1;
         end
         elapsed = now - combo_start;
         if (!combo_on) begin
            combo_on = 1'b1;
            combo_start = now;
            combo_long_reported = 1'b0;
            short_blocked[0] = 1'b1;
            short_blocked[1] = 1'b1;
         end else if (!combo_long_reported && elapsed >= {16'd0, hold_threshold}) begin
            combo_long_reported = 1'b1;
            long_reported[0] = 1'b1;
            long_reported[1] = 1'b1;
            poll_events.push_back(tbpc_pkg::EV_BOTH_LONG);
         end
      end else begin
         combo_on = 1'b0;
         combo_long_reported = 1'b0;
         step_button(0, l, now);
         step_button(1, r, now);
      end
      if (poll_events.size() == 0)
         poll_events.push_back(tbpc_pkg::EV_NONE);
   endtask

   task automatic offer_poll(input logic l, input logic r, input logic [31:0] stamp,
                             input logic typed, input tbpc_pkg::event_code_type code,
                             input logic lp, input logic rp);
      int gap;
      press_event_type item;
      gap = steady_run ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {6'd0, stamp, r, l};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      classify_poll(l, r, stamp);
      polls_sent++;
      if (typed) begin
         item.code = code;
         item.left_stable = lp;
         item.right_stable = rp;
         item.last = 1'b1;
         awaited_events.push_back(item);
      end else begin
         for (int k = 0; k < poll_events.size(); k++) begin
            item.code = poll_events[k];
            item.left_stable = stable_level[0];
            item.right_stable = stable_level[1];
            item.last = (k == poll_events.size() - 1);
            awaited_events.push_back(item);
         end
      end
      @(negedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (awaited_events.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      hold_threshold = value;
      thresholds_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_poll(input logic l, input logic r, input logic [31:0] stamp);
      stim_row_type row;
      row = '0;
      row.kind = ROW_POLL;
      row.left = l;
      row.right = r;
      row.stamp = stamp;
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic l, input logic r, input logic [31:0] stamp,
                              input tbpc_pkg::event_code_type code, input logic lp,
                              input logic rp);
      stim_row_type row;
      row = '0;
      row.kind = ROW_POLL;
      row.left = l;
      row.right = r;
      row.stamp = stamp;
      row.typed = 1'b1;
      row.code = code;
      row.left_stable = lp;
      row.right_stable = rp;
      directed_rows.push_back(row);
   endtask

   task automatic add_threshold(input logic [15:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_THRESHOLD;
      row.value = value;
      directed_rows.push_back(row);
   endtask

   initial begin : stimulus
      int          th;
      int          step_limit;
      int          roll;
      int          pick;
      logic        held_l;
      logic        held_r;
      logic [31:0] stamp;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      reset = 1'b1;
      hold_threshold = tbpc_pkg::LONG_PRESS_RESET;
      for (int k = 0; k < 2; k++) begin
         prev_sample[k] = 1'b0;
         stable_level[k] = 1'b0;
         short_blocked[k] = 1'b0;
         long_reported[k] = 1'b0;
         press_start[k] = '0;
      end
      combo_on = 1'b0;
      combo_start = '0;
      combo_long_reported = 1'b0;
      any_reported = 1'b0;
      steady_run = 1'b0;

      // Quiet poll, then a left short press, all under the reset threshold.
      add_checked(1'b0, 1'b0, 32'd0, tbpc_pkg::EV_NONE, 1'b0, 1'b0);
      add_checked(1'b1, 1'b0, 32'd100, tbpc_pkg::EV_ANY, 1'b0, 1'b0);
      add_checked(1'b1, 1'b0, 32'd110, tbpc_pkg::EV_NONE, 1'b1, 1'b0);
      add_checked(1'b0, 1'b0, 32'd150, tbpc_pkg::EV_NONE, 1'b1, 1'b0);
      add_checked(1'b0, 1'b0, 32'd160, tbpc_pkg::EV_LEFT_SHORT, 1'b0, 1'b0);
      // Right long press exactly at the threshold; its release stays silent.
      add_checked(1'b0, 1'b1, 32'd1000, tbpc_pkg::EV_ANY, 1'b0, 1'b0);
      add_checked(1'b0, 1'b1, 32'd1010, tbpc_pkg::EV_NONE, 1'b0, 1'b1);
      add_checked(1'b0, 1'b1, 32'd3010, tbpc_pkg::EV_RIGHT_LONG, 1'b0, 1'b1);
      add_poll(1'b0, 1'b0, 32'd3020);
      add_poll(1'b0, 1'b0, 32'd3030);
      // Combo: the first poll raises the any-press event and starts the combo timer.
      add_checked(1'b1, 1'b1, 32'd5000, tbpc_pkg::EV_ANY, 1'b1, 1'b1);
      add_checked(1'b1, 1'b1, 32'd7000, tbpc_pkg::EV_BOTH_LONG, 1'b1, 1'b1);
      add_poll(1'b0, 1'b0, 32'd8200);
      add_poll(1'b0, 1'b0, 32'd8210);
      // A left press outlives a short combo and is timed from its old start.
      add_poll(1'b1, 1'b0, 32'd10000);
      add_poll(1'b1, 1'b0, 32'd10010);
      add_poll(1'b1, 1'b1, 32'd10020);
      add_poll(1'b1, 1'b0, 32'd13000);
      add_poll(1'b0, 1'b0, 32'd13010);
      add_poll(1'b0, 1'b0, 32'd13020);
      // A hold across the wrap of the time stamp.
      add_poll(1'b0, 1'b1, 32'hFFFF_FC00);
      add_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
      add_poll(1'b0, 1'b1, 32'h0000_07CF);
      add_poll(1'b0, 1'b0, 32'h0000_07D0);
      add_poll(1'b0, 1'b0, 32'h0000_07D1);
      // A zero threshold makes the first stable poll a long press.
      add_threshold(16'd0);
      add_checked(1'b1, 1'b0, 32'd20, tbpc_pkg::EV_ANY, 1'b0, 1'b0);
      add_checked(1'b1, 1'b0, 32'd20, tbpc_pkg::EV_LEFT_LONG, 1'b1, 1'b0);
      add_poll(1'b0, 1'b0, 32'd20);
      add_poll(1'b0, 1'b0, 32'd20);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_THRESHOLD) begin
            write_threshold(directed_rows[i].value);
         end else begin
            offer_poll(directed_rows[i].left, directed_rows[i].right, directed_rows[i].stamp,
                       directed_rows[i].typed, directed_rows[i].code,
                       directed_rows[i].left_stable, directed_rows[i].right_stable);
         end
      end

      held_l = 1'b0;
      held_r = 1'b0;
      stamp = $urandom();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: th = $urandom_range(1, 40);
            1: th = 0;
            2: th = 65535;
            3: th = 1;
            7: th = $urandom_range(1, 65535);
            default: th = $urandom_range(1, 300);
         endcase
         step_limit = th / 6 + 3;
         write_threshold(th[15:0]);
         steady_run = (phase == 2 || phase == 5);
         for (int n = 0; n < PHASE_POLLS; n++) begin
            roll = $urandom_range(0, 49);
            if (roll == 0)
               stamp = $urandom();
            else if (roll == 1)
               stamp = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else
               stamp = stamp + $urandom_range(0, step_limit);
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               pick = $urandom_range(0, 3);
               held_l = pick[0];
               held_r = pick[1];
            end
            if (roll >= 92) begin
               pick = $urandom_range(0, 3);
               offer_poll(pick[0], pick[1], stamp, 1'b0, tbpc_pkg::EV_NONE, 1'b0, 1'b0);
            end else begin
               offer_poll(held_l, held_r, stamp, 1'b0, tbpc_pkg::EV_NONE, 1'b0, 1'b0);
            end
         end
      end
      steady_run = 1'b0;
      req_tvalid <= 1'b0;

      while (awaited_events.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d polls, %0d results, %0d threshold writes and a %0d-cycle hold-off.",
               polls_sent, results_checked, thresholds_written, HOLD_OFF_CYCLES);
      $display("Events: any %0d, short %0d, long %0d, both-long %0d, quiet %0d.",
               event_tally[tbpc_pkg::EV_ANY],
               event_tally[tbpc_pkg::EV_LEFT_SHORT] + event_tally[tbpc_pkg::EV_RIGHT_SHORT],
               event_tally[tbpc_pkg::EV_LEFT_LONG] + event_tally[tbpc_pkg::EV_RIGHT_LONG],
               event_tally[tbpc_pkg::EV_BOTH_LONG], event_tally[tbpc_pkg::EV_NONE]);
      if (mismatch_count == 0 && awaited_events.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && results_checked >= 250) begin
            stall = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
         end else begin
            stall = steady_run ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Fields are shown as code/left/right/last.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (awaited_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result transfer: %0d/%0b/%0b/%0b",
                        rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[4], rsp_tlast);
         end else begin
            arrived = awaited_events.pop_front();
            event_tally[arrived.code]++;
            if (rsp_tdata[2:0] !== arrived.code || rsp_tdata[3] !== arrived.left_stable ||
                rsp_tdata[4] !== arrived.right_stable || rsp_tlast !== arrived.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result %0d: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                           results_checked, arrived.code, arrived.left_stable,
                           arrived.right_stable, arrived.last, rsp_tdata[2:0],
                           rsp_tdata[3], rsp_tdata[4], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer.", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
